/* rtl/cmcf_pkg.sv */
// Shared types and constants for the 3x3 mean-clamp convolution filter.
package cmcf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;
   localparam int MASK_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int OUT_W      = 15;

   // product of an unsigned pixel and a signed coefficient
   localparam int PROD_W     = PIX_W + 1 + COEF_W;
   localparam int ACC_W      = PROD_W + 4;
   // nine products of 8-bit pixels and 8-bit coefficients fit in 20 signed bits
   localparam int SUM_W      = 20;

   // divide by nine: q = (s * DIV_MUL) >> DIV_SHIFT, exact for s < 2**(SUM_W-1)
   localparam int DIV_SHIFT  = 23;
   localparam int DIV_MUL_W  = 20;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'((2 ** DIV_SHIFT + 8) / 9);
   localparam int DIV_PROD_W = SUM_W - 1 + DIV_MUL_W;
   localparam int QUOT_W     = DIV_PROD_W - DIV_SHIFT;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASK_TOP = 3'd0,
      CSR_MASK_MID = 3'd1,
      CSR_MASK_BOT = 3'd2,
      CSR_WIDTH    = 3'd3,
      CSR_HEIGHT   = 3'd4
   } csr_index_type;

   typedef logic [2:0][MASK_W-1:0] mask_type;
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [COL_W-1:0] wm1;
      logic [ROW_W-1:0] hm1;
   } geom_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] up1;
      logic [PIX_W-1:0] up2;
      logic             win_valid;
      logic             last;
   } column_type;

endpackage

/* rtl/cmcf_line_buf.sv */
// Raster position counters and the two line stores that supply one window column per request.
module cmcf_line_buf
   import cmcf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] pixel_value,
   input  logic             frame_start,
   input  geom_type         geom,
   output logic             out_valid,
   input  logic             out_ready,
   output column_type       out_col
);

   logic [PIX_W-1:0] line_store_a_mem [MAX_WIDTH];
   logic [PIX_W-1:0] line_store_b_mem [MAX_WIDTH];

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_win_ff;
   logic             s1_last_ff;
   logic [PIX_W-1:0] rd_a_ff;
   logic [PIX_W-1:0] rd_b_ff;
   logic             hz_ff;
   logic [PIX_W-1:0] held_ff;

   logic [COL_W-1:0] c_cur;
   logic [ROW_W-1:0] r_cur;
   logic             accept;
   logic             s1_move;
   logic             end_col;
   logic             end_row;

   assign s1_move   = s1_valid_ff && out_ready;
   assign req_ready = !s1_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   assign c_cur   = frame_start ? '0 : col_ff;
   assign r_cur   = frame_start ? '0 : row_ff;
   assign end_col = (c_cur >= geom.wm1);
   assign end_row = (r_cur >= geom.hm1);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         if (end_col) begin
            col_in = '0;
            row_in = end_row ? '0 : r_cur + ROW_W'(1);
         end else begin
            col_in = c_cur + COL_W'(1);
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line stores; row r-2 store is written as the column leaves, so a request at the
   // same address accepted as that column leaves takes that value from held_ff
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_a_ff                 <= line_store_a_mem[c_cur];
         rd_b_ff                 <= line_store_b_mem[c_cur];
         line_store_a_mem[c_cur] <= pixel_value;
      end
      if (s1_move) begin
         line_store_b_mem[s1_col_ff] <= rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= c_cur;
         s1_pix_ff  <= pixel_value;
         s1_win_ff  <= (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
         s1_last_ff <= end_row && end_col;
         hz_ff      <= s1_move && (s1_col_ff == c_cur);
      end
      if (s1_move) begin
         held_ff <= rd_a_ff;
      end
   end

   assign out_valid         = s1_valid_ff;
   assign out_col.pix       = s1_pix_ff;
   assign out_col.up1       = rd_a_ff;
   assign out_col.up2       = hz_ff ? held_ff : rd_b_ff;
   assign out_col.win_valid = s1_win_ff;
   assign out_col.last      = s1_last_ff;

endmodule

/* rtl/cmcf_window_mac.sv */
// 3x3 window register, nine coefficient products and their sum.
module cmcf_window_mac
   import cmcf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  column_type              in_col,
   input  mask_type                mask,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [SUM_W-1:0] out_sum,
   output logic                    out_last
);

   window_type win_ff, win_in;
   logic       a_valid_ff, a_valid_in;
   logic       a_last_ff;

   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [PROD_W-1:0] prod_in [9];
   logic                     b_valid_ff, b_valid_in;
   logic                     b_last_ff;

   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic                     c_valid_ff, c_valid_in;
   logic                     c_last_ff;

   logic a_load, b_load, c_load;
   logic in_take;

   assign c_load   = !c_valid_ff || out_ready;
   assign b_load   = !b_valid_ff || c_load;
   assign a_load   = !a_valid_ff || b_load;
   assign in_ready = a_load;
   assign in_take  = in_valid && a_load;

   always_comb begin
      win_in = win_ff;
      if (in_take) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = in_col.up2;
         win_in[1][2] = in_col.up1;
         win_in[2][2] = in_col.pix;
      end
   end

   always_comb begin
      logic signed [COEF_W-1:0] coef;
      logic signed [PIX_W:0]    px;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            coef           = mask[i][8*j +: COEF_W];
            px             = {1'b0, win_ff[i][j]};
            prod_in[3*i+j] = PROD_W'(px * coef);
         end
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 9; k++) begin
         acc = acc + ACC_W'(prod_ff[k]);
      end
      sum_in = acc[SUM_W-1:0];
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      c_valid_in = c_valid_ff;
      if (a_load) begin
         a_valid_in = in_valid && in_col.win_valid;
      end
      if (b_load) begin
         b_valid_in = a_valid_ff;
      end
      if (c_load) begin
         c_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         win_ff     <= win_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         a_last_ff <= in_col.last;
      end
      if (b_load) begin
         prod_ff   <= prod_in;
         b_last_ff <= a_last_ff;
      end
      if (c_load) begin
         sum_ff    <= sum_in;
         c_last_ff <= b_last_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_sum   = sum_ff;
   assign out_last  = c_last_ff;

endmodule

/* rtl/cmcf_div_clamp.sv */
// Divide-by-nine with negative clamp and saturation at OUT_MAX, and the result register.
module cmcf_div_clamp
   import cmcf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [SUM_W-1:0] in_sum,
   input  logic                    in_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_filtered_value,
   output logic                    rsp_last_of_image
);

   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] value_ff, value_in;
   logic             last_ff;

   logic [SUM_W-2:0]      mag;
   logic [DIV_PROD_W-1:0] prod;
   logic [QUOT_W-1:0]     quot;
   logic                  take;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   assign mag  = in_sum[SUM_W-2:0];
   assign prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_MUL);
   assign quot = prod[DIV_PROD_W-1:DIV_SHIFT];

   always_comb begin
      if (in_sum[SUM_W-1] || (in_sum == '0)) begin
         value_in = '0;
      end else if (quot > QUOT_W'(OUT_MAX)) begin
         value_in = OUT_MAX;
      end else begin
         value_in = quot[OUT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_ready) begin
         rsp_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= value_in;
         last_ff  <= in_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = value_ff;
   assign rsp_last_of_image  = last_ff;

endmodule

/* rtl/conv3x3_mean_clamp_filter_core.sv */
// Top level of the 3x3 mean-clamp convolution filter: registers, pipeline and checks.
//
// Pixels enter in raster order, one request per cycle when the result side keeps up.
// A request waits while req_ready is low. The pipeline is five registers deep: line
// store read, window, products, sum, and divide-by-nine into the result register. Only
// fully covered window positions give a result, (height-2)*(width-2) per image, with
// rsp_last_of_image on the final one. The rate is one pixel per cycle while the result
// side keeps up, set by one read and one write to each line store per cycle. The line
// stores are not cleared at reset; write the registers only while no request is in
// flight.
module conv3x3_mean_clamp_filter_core
   import cmcf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel_value,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_W-1:0]     rsp_filtered_value,
   output logic                 rsp_last_of_image,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASK_W-1:0]    csr_write_data
);

   mask_type         mask_ff, mask_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   geom_type         geom;

   always_comb begin
      mask_in   = mask_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MASK_TOP: mask_in[0] = csr_write_data;
            CSR_MASK_MID: mask_in[1] = csr_write_data;
            CSR_MASK_BOT: mask_in[2] = csr_write_data;
            CSR_WIDTH:    width_in   = csr_write_data[DIM_W-1:0];
            CSR_HEIGHT:   height_in  = csr_write_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         width_ff  <= DIM_W'(3);
         height_ff <= DIM_W'(3);
      end else begin
         mask_ff   <= mask_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // saturate geometry to [3, max] and keep size minus one
   always_comb begin
      if (width_ff < DIM_W'(3)) begin
         geom.wm1 = COL_W'(2);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         geom.wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         geom.wm1 = COL_W'(width_ff - DIM_W'(1));
      end
      if (height_ff < DIM_W'(3)) begin
         geom.hm1 = ROW_W'(2);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         geom.hm1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         geom.hm1 = ROW_W'(height_ff - DIM_W'(1));
      end
   end

   logic                    col_valid;
   logic                    col_ready;
   column_type              col;
   logic                    sum_valid;
   logic                    sum_ready;
   logic signed [SUM_W-1:0] sum;
   logic                    sum_last;

   cmcf_line_buf u_line_buf (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .pixel_value (req_pixel_value),
      .frame_start (req_frame_start),
      .geom        (geom),
      .out_valid   (col_valid),
      .out_ready   (col_ready),
      .out_col     (col)
   );

   cmcf_window_mac u_window_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (col_valid),
      .in_ready  (col_ready),
      .in_col    (col),
      .mask      (mask_ff),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum),
      .out_last  (sum_last)
   );

   cmcf_div_clamp u_div_clamp (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (sum_valid),
      .in_ready           (sum_ready),
      .in_sum             (sum),
      .in_last            (sum_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_last_of_image  (rsp_last_of_image)
   );

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_filtered_value <= OUT_W'(32385)))
      else $error("filtered value beyond the largest mean of 8-bit pixels");

   a_geom_range: assert property (@(posedge clock) disable iff (reset)
      (geom.wm1 >= COL_W'(2)) && (geom.hm1 >= ROW_W'(2)))
      else $error("clamped geometry below three");

   a_col_hold: assert property (@(posedge clock) disable iff (reset)
      (col_valid && !col_ready) |=> (col_valid && $stable(col.pix) && $stable(col.up1)))
      else $error("stalled window column changed");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !col_valid |-> req_ready)
      else $error("request side stalled with an empty line stage");

endmodule

/* dv/tb_conv3x3_mean_clamp_filter_core.sv */
// Testbench for the 3x3 mean-clamp convolution filter core: driven requests, predicted results.
`timescale 1ns / 1ps

module tb_conv3x3_mean_clamp_filter_core;
   import cmcf_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int DRAIN_CYCLES  = 12;
   localparam int LONG_HOLD     = 600;
   localparam int RANDOM_TARGET = 1600;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int MEAN_DIV      = 9;
   localparam int MASK_BYTE     = 8;
   localparam int HOLD_WIDTH    = 12;
   localparam int HOLD_HEIGHT   = 9;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             last;
   } filtered_type;

   class mean_filter_scoreboard;
      localparam int MAX_REPORTS = 50;

      logic [MASK_W-1:0] mask_rows [3];
      logic [DIM_W-1:0]  width_reg;
      logic [DIM_W-1:0]  height_reg;
      logic [PIX_W-1:0]  row_above [MAX_WIDTH];
      logic [PIX_W-1:0]  row_above2 [MAX_WIDTH];
      logic [PIX_W-1:0]  win [3][3];
      int unsigned       col;
      int unsigned       row;
      filtered_type      pending_means [$];
      int                mismatches;

      function new();
         for (int i = 0; i < 3; i++) begin
            mask_rows[i] = '0;
            for (int j = 0; j < 3; j++) win[i][j] = '0;
         end
         for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
         end
         width_reg  = DIM_W'(3);
         height_reg = DIM_W'(3);
         col        = 0;
         row        = 0;
         mismatches = 0;
      endfunction

      function int unsigned dim_used(logic [DIM_W-1:0] v, int unsigned hi);
         if (v < 3) return 3;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned width_in_use();
         return dim_used(width_reg, MAX_WIDTH);
      endfunction

      function int unsigned height_in_use();
         return dim_used(height_reg, MAX_HEIGHT);
      endfunction

      function void apply_setting(csr_index_type idx, logic [MASK_W-1:0] data);
         case (idx)
            CSR_MASK_TOP: mask_rows[0] = data;
            CSR_MASK_MID: mask_rows[1] = data;
            CSR_MASK_BOT: mask_rows[2] = data;
            CSR_WIDTH:    width_reg    = data[DIM_W-1:0];
            CSR_HEIGHT:   height_reg   = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      // one accepted pixel: advance the line stores and window, queue the mean if covered
      function void note_pixel(logic [PIX_W-1:0] pix, logic fs);
         int unsigned w, h, c, r;
         logic [PIX_W-1:0] up1, up2;
         logic signed [COEF_W-1:0] coef;
         int pix_i, coef_i, acc, q;
         filtered_type e;
         w = width_in_use();
         h = height_in_use();
         if (fs) begin
            col = 0;
            row = 0;
         end
         c = col % MAX_WIDTH;
         r = row;
         up1 = row_above[c];
         up2 = row_above2[c];
         row_above2[c] = up1;
         row_above[c]  = pix;
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = up2;
         win[1][2] = up1;
         win[2][2] = pix;
         if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) begin
                  coef   = mask_rows[i][MASK_BYTE*j +: COEF_W];
                  pix_i  = win[i][j];
                  coef_i = coef;
                  acc   += pix_i * coef_i;
               end
            q = (acc > 0) ? acc / MEAN_DIV : 0;
            if (q > int'(OUT_MAX)) q = int'(OUT_MAX);
            e.value = OUT_W'(q);
            e.last  = (r >= h - 1) && (c >= w - 1);
            pending_means.push_back(e);
         end
         if (c >= w - 1) begin
            col = 0;
            row = (r >= h - 1) ? 0 : r + 1;
         end else begin
            col = c + 1;
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
      endtask

      task check_filtered(logic [OUT_W-1:0] value, logic last);
         filtered_type e;
         if (pending_means.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d last %0b", value, last));
            return;
         end
         e = pending_means.pop_front();
         if (value !== e.value)
            report_mismatch($sformatf("filtered_value %0d, expected %0d", value, e.value));
         if (last !== e.last)
            report_mismatch($sformatf("last_of_image %0b, expected %0b", last, e.last));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_value = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_W-1:0]     rsp_filtered_value;
   logic                 rsp_last_of_image;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MASK_TOP;
   logic [MASK_W-1:0]    csr_write_data = '0;

   mean_filter_scoreboard filter_board = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left = 0;
   int unsigned sent_pixels = 0;
   int unsigned cycle_count = 0;

   conv3x3_mean_clamp_filter_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_value    (req_pixel_value),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_last_of_image  (rsp_last_of_image),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         filter_board.note_pixel(req_pixel_value, req_frame_start);
      if (!reset && rsp_valid && rsp_ready)
         filter_board.check_filtered(rsp_filtered_value, rsp_last_of_image);
   end

   // result side: random stalls, plus a long hold-off when one is armed
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic [MASK_W-1:0] pick_mask();
      case ($urandom_range(7))
         0: return 24'h7F7F7F;
         1: return 24'h808080;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return MASK_W'($urandom);
      endcase
   endfunction

   // geometry value in the low bits, noise above
   function automatic logic [MASK_W-1:0] dim_word(int unsigned v);
      logic [MASK_W-1:0] d;
      d = MASK_W'($urandom);
      d[DIM_W-1:0] = DIM_W'(v);
      return d;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [MASK_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      filter_board.apply_setting(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_masks(input int unsigned pct);
      if ($urandom_range(99) < pct) write_csr(CSR_MASK_TOP, pick_mask());
      if ($urandom_range(99) < pct) write_csr(CSR_MASK_MID, pick_mask());
      if ($urandom_range(99) < pct) write_csr(CSR_MASK_BOT, pick_mask());
   endtask

   // entered and left at a falling edge; valid stays high between back-to-back requests
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_pixels++;
      @(negedge clock);
   endtask

   task automatic send_run(input int unsigned n, input logic first_fs,
                           input int unsigned noise_pct);
      for (int unsigned i = 0; i < n; i++)
         send_pixel(pick_pixel(), (i == 0 && first_fs) || ($urandom_range(99) < noise_pct));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (filter_board.pending_means.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // widening mid-image would expose unwritten line store entries, so it restarts the frame
   task automatic run_segment();
      int unsigned kind, w_val, h_val, w, h, n;
      logic fs_first;
      kind  = $urandom_range(11);
      w_val = (kind == 0) ? $urandom_range(MAX_WIDTH + 1, 2047) : $urandom_range(0, 12);
      h_val = (kind == 1) ? $urandom_range(MAX_HEIGHT + 1, 2047) : $urandom_range(0, 9);
      drain();
      write_masks(50);
      fs_first = filter_board.dim_used(DIM_W'(w_val), MAX_WIDTH) >
                 filter_board.width_in_use();
      write_csr(CSR_WIDTH, dim_word(w_val));
      write_csr(CSR_HEIGHT, dim_word(h_val));
      w = filter_board.width_in_use();
      h = filter_board.height_in_use();
      case (kind)
         0: send_run($urandom_range(20, 60), fs_first, 0);
         1: send_run(w * $urandom_range(3, 8), fs_first, 0);
         2: send_run($urandom_range(1, 2 * w * h), fs_first, 8);
         3: begin
            send_run($urandom_range(1, w * h - 1), 1'b1, 0);
            drain();
            write_csr(CSR_WIDTH, dim_word($urandom_range(0, w)));
            write_csr(CSR_HEIGHT, dim_word($urandom_range(0, 9)));
            n = filter_board.width_in_use() * filter_board.height_in_use();
            send_run(n, 1'b0, 0);
         end
         default: begin
            n = $urandom_range(1, 3);
            for (int unsigned k = 0; k < n; k++)
               send_run(w * h, fs_first || (k == 0) || ($urandom_range(3) != 0), 0);
         end
      endcase
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 28;
      recv_idle_pct = 68;

      // full positive mask on a saturated image, geometry below range
      write_csr(CSR_MASK_TOP, 24'h7F7F7F);
      write_csr(CSR_MASK_MID, 24'h7F7F7F);
      write_csr(CSR_MASK_BOT, 24'h7F7F7F);
      write_csr(CSR_WIDTH, dim_word(0));
      write_csr(CSR_HEIGHT, dim_word(2));
      for (int unsigned i = 0; i < 9; i++) send_pixel('1, i == 0);
      drain();

      // all-negative mask clamps to zero; stream wraps into the next image without a start
      write_csr(CSR_MASK_TOP, 24'h808080);
      write_csr(CSR_MASK_MID, 24'h808080);
      write_csr(CSR_MASK_BOT, 24'h808080);
      for (int unsigned i = 0; i < 9; i++) send_pixel(i[0] ? '1 : '0, 1'b0);
      drain();

      // frame restart mid-image, then the height shrinks under a partly sent image
      write_csr(CSR_MASK_TOP, 24'h01FF7F);
      write_csr(CSR_MASK_MID, 24'h80407F);
      write_csr(CSR_MASK_BOT, 24'h0203FE);
      write_csr(CSR_HEIGHT, dim_word(4));
      send_pixel(pick_pixel(), 1'b0);
      send_run(8, 1'b1, 0);
      drain();
      write_csr(CSR_HEIGHT, dim_word(3));
      send_pixel(pick_pixel(), 1'b0);

      while (sent_pixels < RANDOM_TARGET) begin
         if (sent_pixels < RANDOM_TARGET / 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 68;
         end else if (sent_pixels < 2 * RANDOM_TARGET / 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_segment();
      end

      // two full images while the result side holds off, so the requests stall
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_masks(100);
      write_csr(CSR_WIDTH, dim_word(HOLD_WIDTH));
      write_csr(CSR_HEIGHT, dim_word(HOLD_HEIGHT));
      hold_left = LONG_HOLD;
      send_run(2 * HOLD_WIDTH * HOLD_HEIGHT, 1'b1, 0);
      drain();

      if (filter_board.mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
